>>> hw/rtl/fsip_pkg.sv
// Shared types, character constants and helpers for the integer format printer.
package fsip_pkg;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_A_UPPER = 8'h41;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_X       = 8'h78;

    // bits consumed per cycle by the binary-to-BCD converter
    localparam int DAB_BITS = 4;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [1:0] {
        OP_CHAR = 2'd0,
        OP_DEC  = 2'd1,
        OP_HEX  = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] ch;
        logic       neg;
    } cmd_hdr_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d < 4'd10) begin
            return CH_ZERO + {4'd0, d};
        end else begin
            return CH_A_UPPER + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

>>> hw/rtl/fsip_front.sv
// Front end: accepts format characters, tracks the pending percent, queues commands.
module fsip_front #(
    parameter int ARG_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_format_char,
    input  logic [ARG_WIDTH-1:0]  s_argument,
    input  logic                  q_full,
    output logic                  q_push,
    output fsip_pkg::cmd_hdr_t    q_hdr,
    output logic [ARG_WIDTH-1:0]  q_mag
);
    import fsip_pkg::*;

    logic pending_reg;
    logic pending_next;
    logic accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pending_next = pending_reg;
        q_push       = 1'b0;
        q_hdr.op     = OP_CHAR;
        q_hdr.ch     = s_format_char;
        q_hdr.neg    = 1'b0;
        q_mag        = s_argument;
        if (accept) begin
            if (s_format_char == CH_NUL) begin
                pending_next = 1'b0;
            end else if (!pending_reg) begin
                if (s_format_char == CH_PERCENT) begin
                    pending_next = 1'b1;
                end else begin
                    q_push = 1'b1;
                end
            end else begin
                pending_next = 1'b0;
                case (s_format_char)
                    CH_D: begin
                        q_push    = 1'b1;
                        q_hdr.op  = OP_DEC;
                        q_hdr.neg = s_argument[ARG_WIDTH-1];
                        if (s_argument[ARG_WIDTH-1]) begin
                            q_mag = (~s_argument) + {{(ARG_WIDTH-1){1'b0}}, 1'b1};
                        end
                    end
                    CH_X: begin
                        q_push   = 1'b1;
                        q_hdr.op = OP_HEX;
                    end
                    CH_C: begin
                        q_push   = 1'b1;
                        q_hdr.ch = s_argument[7:0];
                    end
                    CH_PERCENT: begin
                        q_push = 1'b1;
                    end
                    default: begin
                        q_push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
        end
    end

endmodule

>>> hw/rtl/fsip_queue.sv
// Two-entry command queue between the front and back ends.
module fsip_queue #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);
    import fsip_pkg::*;

    logic [DATA_W-1:0] mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> hw/rtl/fsip_back.sv
// Back end: binary-to-BCD conversion, leading-zero scan and character output.
module fsip_back #(
    parameter int ARG_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  fsip_pkg::cmd_hdr_t    q_hdr,
    input  logic [ARG_WIDTH-1:0]  q_mag,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_char,
    output logic                  m_last_of_run
);
    import fsip_pkg::*;

    localparam int PAD_W  = ((ARG_WIDTH + DAB_BITS - 1) / DAB_BITS) * DAB_BITS;
    localparam int STEPS  = PAD_W / DAB_BITS;
    localparam int NDEC   = (ARG_WIDTH * 30103) / 100000 + 1;
    localparam int NHEX   = PAD_W / 4;
    localparam int NDIG   = (NDEC > NHEX) ? NDEC : NHEX;
    localparam int DIG_W  = NDIG * 4;
    localparam int PTR_W  = $clog2(NDIG);
    localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CONV  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SIGN  = 6'b001000,
        S_DIGIT = 6'b010000,
        S_CHAR  = 6'b100000
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic [PAD_W-1:0]  bin_reg, bin_next;
    logic [DIG_W-1:0]  dig_reg, dig_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic              neg_reg, neg_next;
    logic [7:0]        char_reg, char_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_char_reg, m_char_next;
    logic              m_last_reg, m_last_next;

    logic [DIG_W-1:0]  dab_dig;
    logic [PAD_W-1:0]  dab_bin;
    logic [PTR_W-1:0]  scan_ptr;
    logic              out_free;

    assign m_valid       = m_valid_reg;
    assign m_out_char    = m_char_reg;
    assign m_last_of_run = m_last_reg;
    assign out_free      = !m_valid_reg || m_ready;

    // shift-add-3, DAB_BITS bits per cycle
    always_comb begin
        logic [DIG_W-1:0] d;
        logic [PAD_W-1:0] b;
        d = dig_reg;
        b = bin_reg;
        for (int s = 0; s < DAB_BITS; s++) begin
            for (int k = 0; k < NDIG; k++) begin
                if (d[k*4 +: 4] >= 4'd5) begin
                    d[k*4 +: 4] = d[k*4 +: 4] + 4'd3;
                end
            end
            d = {d[DIG_W-2:0], b[PAD_W-1]};
            b = {b[PAD_W-2:0], 1'b0};
        end
        dab_dig = d;
        dab_bin = b;
    end

    // most significant nonzero digit, zero if all digits are zero
    always_comb begin
        scan_ptr = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (dig_reg[i*4 +: 4] != 4'd0) begin
                scan_ptr = PTR_W'(i);
            end
        end
    end

    always_comb begin
        logic       emit;
        logic [7:0] emit_char;
        logic       emit_last;
        emit       = 1'b0;
        emit_char  = char_reg;
        emit_last  = 1'b0;
        state_next = state_reg;
        bin_next   = bin_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        neg_next   = neg_reg;
        char_next  = char_reg;
        q_pop      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_hdr.op)
                        OP_CHAR: begin
                            char_next  = q_hdr.ch;
                            state_next = S_CHAR;
                        end
                        OP_DEC: begin
                            bin_next   = PAD_W'(q_mag);
                            dig_next   = '0;
                            cnt_next   = '0;
                            neg_next   = q_hdr.neg;
                            state_next = S_CONV;
                        end
                        OP_HEX: begin
                            dig_next   = DIG_W'(q_mag);
                            neg_next   = 1'b0;
                            state_next = S_SCAN;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV: begin
                dig_next = dab_dig;
                bin_next = dab_bin;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                ptr_next   = scan_ptr;
                state_next = neg_reg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_char  = CH_MINUS;
                    emit_last  = 1'b0;
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = digit_char(dig_reg[ptr_reg*4 +: 4]);
                    emit_last = (ptr_reg == '0);
                    if (ptr_reg == '0) begin
                        state_next = S_IDLE;
                    end else begin
                        ptr_next = ptr_reg - 1'b1;
                    end
                end
            end
            S_CHAR: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_char  = char_reg;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_char_next  = emit_char;
            m_last_next  = emit_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg    <= bin_next;
        dig_reg    <= dig_next;
        cnt_reg    <= cnt_next;
        ptr_reg    <= ptr_next;
        neg_reg    <= neg_next;
        char_reg   <= char_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

endmodule

>>> hw/rtl/format_string_integer_printer_core.sv
// Integer format printer: top level joining front end, command queue and back end.
//
// Input channel (s_valid/s_ready): one format character per request with an
// argument word. Ordinary characters are copied, '%' arms a conversion, and
// the next character selects 'd', 'x', 'c' or '%'. A NUL ends the format.
// Output channel (m_valid/m_ready): one character per request, m_last_of_run
// set on the final character produced by an input request.
// The front end takes a request every cycle while the two-entry command queue
// has room; '%', NUL and unknown conversions produce no queue entry.
// Back end steps per command, with W = ARG_WIDTH rounded up to a nibble:
//   plain character, 'c', '%%': fetch, then the character out
//   'x': fetch, leading-zero scan, then each hex digit (up to 8 at W=32)
//   'd': fetch, BCD conversion of W bits, scan, sign if negative, then digits
//        (up to 10 at W=32); a new command is fetched only from idle.
// The output register holds a single character; the back end can replace it as
// it is taken; when m_ready is low the back end stalls, then the queue fills and
// s_ready drops. Reset clears the pending '%', the queue and the output valid.
module format_string_integer_printer_core #(
    parameter int ARG_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_format_char,
    input  logic [ARG_WIDTH-1:0] s_argument,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_char,
    output logic                 m_last_of_run
);
    import fsip_pkg::*;

    localparam int Q_W = $bits(cmd_hdr_t) + ARG_WIDTH;

    logic                 q_full;
    logic                 q_empty;
    logic                 q_push;
    logic                 q_pop;
    cmd_hdr_t             push_hdr;
    logic [ARG_WIDTH-1:0] push_mag;
    logic [Q_W-1:0]       pop_data;
    cmd_hdr_t             pop_hdr;
    logic [ARG_WIDTH-1:0] pop_mag;

    assign pop_hdr = cmd_hdr_t'(pop_data[Q_W-1:ARG_WIDTH]);
    assign pop_mag = pop_data[ARG_WIDTH-1:0];

    fsip_front #(
        .ARG_WIDTH(ARG_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_format_char(s_format_char),
        .s_argument   (s_argument),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_hdr        (push_hdr),
        .q_mag        (push_mag)
    );

    fsip_queue #(
        .DATA_W(Q_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data({push_hdr, push_mag}),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (pop_data),
        .empty    (q_empty)
    );

    fsip_back #(
        .ARG_WIDTH(ARG_WIDTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (!q_empty),
        .q_hdr        (pop_hdr),
        .q_mag        (pop_mag),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_last_of_run(m_last_of_run)
    );

endmodule

>>> hw/rtl/fsip_checker.sv
// Port-level checks for the integer format printer, bound to the top level.
module fsip_checker #(
    parameter int ARG_WIDTH = 32
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic [7:0]           s_format_char,
    input logic [ARG_WIDTH-1:0] s_argument,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [7:0]           m_out_char,
    input logic                 m_last_of_run
);
    import fsip_pkg::*;

    // set after a '-' that opens a negative decimal
    logic after_minus_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_minus_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            after_minus_reg <= (m_out_char == CH_MINUS) && !m_last_of_run;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) && $stable(m_last_of_run))
        else $error("output request changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_ready))
        else $error("input ready dropped without an accepted request");

    a_minus_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && after_minus_reg |-> m_out_char >= 8'h31 && m_out_char <= 8'h39)
        else $error("negative sign not followed by a nonzero leading digit");

    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !$isunknown({s_format_char, s_argument}))
        else $error("unknown input request accepted");

endmodule

bind format_string_integer_printer_core fsip_checker #(
    .ARG_WIDTH(ARG_WIDTH)
) u_fsip_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_format_char(s_format_char),
    .s_argument   (s_argument),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_char   (m_out_char),
    .m_last_of_run(m_last_of_run)
);
